FILE: rtl/abto_pkg.sv
// Shared types and constants for the acknowledgement barrier with timeout.
// Used by the controller, the datapath and the top level.
package abto_pkg;

   localparam int DEFAULT_MAX_PARTICIPANTS = 16;
   localparam int DEFAULT_KEY_BITS         = 16;

   localparam int OP_W        = 3;
   localparam int REQ_KEY_W   = 16;
   localparam int SERIAL_W    = 32;
   localparam int TIMEOUT_W   = 32;
   localparam int COUNT_OUT_W = 5;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_ADD    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_ACK    = 3'd3,
      OP_COMMIT = 3'd4,
      OP_TICK   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // capture the incoming request
      logic match;      // register key match and free slot
      logic exec;       // apply the operation and load the response
   } cmd_type;

endpackage

FILE: rtl/abto_ctrl.sv
// Controller for the acknowledgement barrier: sequences match and execute
// steps and owns both handshakes. Depends on abto_pkg.
module abto_ctrl
   import abto_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            // hold until the response register can take the result
            if (slot_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_MATCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/abto_dp.sv
// Datapath for the acknowledgement barrier: participant table, counters,
// flags, countdown, timeout register and response register. Depends on abto_pkg.
module abto_dp
   import abto_pkg::*;
#(
   parameter int MAX_PARTICIPANTS = DEFAULT_MAX_PARTICIPANTS,
   parameter int KEY_BITS         = DEFAULT_KEY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [REQ_KEY_W-1:0]   req_key,
   input  logic [SERIAL_W-1:0]    req_serial,
   input  logic                   csr_write,
   input  logic [TIMEOUT_W-1:0]   csr_wdata,
   output logic                   rsp_accepted,
   output logic                   rsp_key_present,
   output logic                   rsp_key_acked,
   output logic                   rsp_completed_now,
   output logic                   rsp_timed_out_now,
   output logic                   rsp_is_committed,
   output logic                   rsp_is_complete,
   output logic [COUNT_OUT_W-1:0] rsp_pending_count,
   output logic [COUNT_OUT_W-1:0] rsp_member_count
);

   localparam int CNT_W = $clog2(MAX_PARTICIPANTS + 1);

   // request latch
   logic [OP_W-1:0]      op_ff;
   logic [REQ_KEY_W-1:0] key_raw_ff;
   logic [SERIAL_W-1:0]  serial_ff;

   // participant table
   logic [MAX_PARTICIPANTS-1:0] valid_ff, valid_in;
   logic [MAX_PARTICIPANTS-1:0] acked_ff, acked_in;
   logic [KEY_BITS-1:0]         ent_key_ff    [MAX_PARTICIPANTS];
   logic [SERIAL_W-1:0]         ent_serial_ff [MAX_PARTICIPANTS];

   // match results
   logic [MAX_PARTICIPANTS-1:0] hit_ff, hit_in;
   logic [MAX_PARTICIPANTS-1:0] free_oh_ff, free_oh_in;
   logic [MAX_PARTICIPANTS-1:0] free_vec;

   // barrier state
   logic [CNT_W-1:0]     members_ff, members_in;
   logic [CNT_W-1:0]     pending_ff, pending_in;
   logic                 committed_ff, committed_in;
   logic                 complete_ff, complete_in;
   logic                 armed_ff, armed_in;
   logic [TIMEOUT_W-1:0] count_ff, count_in;
   logic [TIMEOUT_W-1:0] count_dec;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   // response register
   logic                   acc_ff, acc_in;
   logic                   present_ff, present_in;
   logic                   kacked_ff, kacked_in;
   logic                   done_ff, done_in;
   logic                   timed_ff, timed_in;
   logic [COUNT_OUT_W-1:0] pend_out_ff, pend_out_in;
   logic [COUNT_OUT_W-1:0] memb_out_ff, memb_out_in;

   logic [KEY_BITS+REQ_KEY_W-1:0]    key_ext;
   logic [KEY_BITS-1:0]              key_m;
   logic [CNT_W+COUNT_OUT_W-1:0]     pend_ext, memb_ext;
   logic                             any_hit, any_free, sel_acked, add_we, fire_req;
   logic [SERIAL_W-1:0]              sel_serial;

   // reduce the key to KEY_BITS bits
   assign key_ext = {{KEY_BITS{1'b0}}, key_raw_ff};
   assign key_m   = key_ext[KEY_BITS-1:0];

   assign free_vec   = ~valid_ff;
   assign free_oh_in = free_vec & (~free_vec + MAX_PARTICIPANTS'(1));

   always_comb begin
      for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
         hit_in[i] = valid_ff[i] && (ent_key_ff[i] == key_m);
      end
   end

   // keys are unique, so at most one hit bit is set
   always_comb begin
      sel_serial = '0;
      sel_acked  = 1'b0;
      for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
         sel_serial = sel_serial | (hit_ff[i] ? ent_serial_ff[i] : '0);
         sel_acked  = sel_acked | (hit_ff[i] & acked_ff[i]);
      end
   end

   assign any_hit   = |hit_ff;
   assign any_free  = |free_oh_ff;
   assign count_dec = (count_ff != '0) ? count_ff - TIMEOUT_W'(1) : '0;

   always_comb begin
      valid_in     = valid_ff;
      acked_in     = acked_ff;
      members_in   = members_ff;
      pending_in   = pending_ff;
      committed_in = committed_ff;
      complete_in  = complete_ff;
      armed_in     = armed_ff;
      count_in     = count_ff;
      acc_in       = 1'b0;
      present_in   = any_hit;
      kacked_in    = any_hit && sel_acked;
      done_in      = 1'b0;
      timed_in     = 1'b0;
      add_we       = 1'b0;
      fire_req     = 1'b0;

      unique case (op_type'(op_ff))
         OP_CLEAR: begin
            valid_in     = '0;
            members_in   = '0;
            pending_in   = '0;
            committed_in = 1'b0;
            complete_in  = 1'b0;
            armed_in     = 1'b0;
            count_in     = '0;
            acc_in       = 1'b1;
            present_in   = 1'b0;
            kacked_in    = 1'b0;
         end
         OP_ADD: begin
            if (!committed_ff && !any_hit && any_free) begin
               add_we     = 1'b1;
               valid_in   = valid_ff | free_oh_ff;
               acked_in   = acked_ff & ~free_oh_ff;
               members_in = members_ff + CNT_W'(1);
               pending_in = pending_ff + CNT_W'(1);
               acc_in     = 1'b1;
               present_in = 1'b1;
               kacked_in  = 1'b0;
            end
         end
         OP_REMOVE: begin
            if (any_hit) begin
               valid_in = valid_ff & ~hit_ff;
               if (members_ff != '0) members_in = members_ff - CNT_W'(1);
               if (!sel_acked && pending_ff != '0) pending_in = pending_ff - CNT_W'(1);
               acc_in     = 1'b1;
               present_in = 1'b0;
               kacked_in  = 1'b0;
               fire_req   = committed_ff && (pending_in == '0);
            end
         end
         OP_ACK: begin
            if (any_hit && sel_serial == serial_ff && !sel_acked) begin
               acked_in = acked_ff | hit_ff;
               if (pending_ff != '0) pending_in = pending_ff - CNT_W'(1);
               acc_in    = 1'b1;
               kacked_in = 1'b1;
               fire_req  = committed_ff && (pending_in == '0);
            end
         end
         OP_COMMIT: begin
            if (!committed_ff) begin
               committed_in = 1'b1;
               acc_in       = 1'b1;
               if (pending_ff == '0) begin
                  fire_req = 1'b1;
               end else if (timeout_ff != '0 && !complete_ff) begin
                  armed_in = 1'b1;
                  count_in = timeout_ff;
               end
            end
         end
         OP_TICK: begin
            if (armed_ff) begin
               acc_in   = 1'b1;
               count_in = count_dec;
               if (count_dec == '0) begin
                  armed_in = 1'b0;
                  fire_req = 1'b1;
                  timed_in = !complete_ff;
               end
            end
         end
         default: ;
      endcase

      // completion fires once and drops the countdown
      if (fire_req && !complete_ff) begin
         complete_in = 1'b1;
         armed_in    = 1'b0;
         count_in    = '0;
         done_in     = 1'b1;
      end
   end

   assign pend_ext    = {{COUNT_OUT_W{1'b0}}, pending_in};
   assign memb_ext    = {{COUNT_OUT_W{1'b0}}, members_in};
   assign pend_out_in = pend_ext[COUNT_OUT_W-1:0];
   assign memb_out_in = memb_ext[COUNT_OUT_W-1:0];
   assign timeout_in  = csr_write ? csr_wdata : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         members_ff   <= '0;
         pending_ff   <= '0;
         committed_ff <= 1'b0;
         complete_ff  <= 1'b0;
         armed_ff     <= 1'b0;
         count_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
         if (cmd.exec) begin
            valid_ff     <= valid_in;
            members_ff   <= members_in;
            pending_ff   <= pending_in;
            committed_ff <= committed_in;
            complete_ff  <= complete_in;
            armed_ff     <= armed_in;
            count_ff     <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= req_operation;
         key_raw_ff <= req_key;
         serial_ff  <= req_serial;
      end
      if (cmd.match) begin
         hit_ff     <= hit_in;
         free_oh_ff <= free_oh_in;
      end
      if (cmd.exec) begin
         acked_ff    <= acked_in;
         acc_ff      <= acc_in;
         present_ff  <= present_in;
         kacked_ff   <= kacked_in;
         done_ff     <= done_in;
         timed_ff    <= timed_in;
         pend_out_ff <= pend_out_in;
         memb_out_ff <= memb_out_in;
      end
      for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
         if (cmd.exec && add_we && free_oh_ff[i]) begin
            ent_key_ff[i]    <= key_m;
            ent_serial_ff[i] <= serial_ff;
         end
      end
   end

   assign rsp_accepted      = acc_ff;
   assign rsp_key_present   = present_ff;
   assign rsp_key_acked     = kacked_ff;
   assign rsp_completed_now = done_ff;
   assign rsp_timed_out_now = timed_ff;
   assign rsp_is_committed  = committed_ff;
   assign rsp_is_complete   = complete_ff;
   assign rsp_pending_count = pend_out_ff;
   assign rsp_member_count  = memb_out_ff;

endmodule

FILE: rtl/ack_barrier_with_timeout.sv
// Top level of the acknowledgement barrier with timeout.
// Instantiates abto_ctrl and abto_dp; depends on abto_pkg.
//
// Each request has a match step, which matches its key against every table
// entry in parallel and finds the lowest free slot, and an execute step, which
// applies the operation and loads the response register. A new request is
// also taken in the execute step, so the next request is taken while the
// current one executes, as long as responses are drained; a held response
// stalls the execute step. The timeout register may be written at any time
// the block has no request in flight; its write channel is always ready.
module ack_barrier_with_timeout
   import abto_pkg::*;
#(
   parameter int MAX_PARTICIPANTS = DEFAULT_MAX_PARTICIPANTS,
   parameter int KEY_BITS         = DEFAULT_KEY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [REQ_KEY_W-1:0]   req_key,
   input  logic [SERIAL_W-1:0]    req_serial,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic                   rsp_key_present,
   output logic                   rsp_key_acked,
   output logic                   rsp_completed_now,
   output logic                   rsp_timed_out_now,
   output logic                   rsp_is_committed,
   output logic                   rsp_is_complete,
   output logic [COUNT_OUT_W-1:0] rsp_pending_count,
   output logic [COUNT_OUT_W-1:0] rsp_member_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TIMEOUT_W-1:0]   csr_wdata
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   abto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   abto_dp #(
      .MAX_PARTICIPANTS (MAX_PARTICIPANTS),
      .KEY_BITS         (KEY_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_serial        (req_serial),
      .csr_write         (csr_valid && csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_accepted      (rsp_accepted),
      .rsp_key_present   (rsp_key_present),
      .rsp_key_acked     (rsp_key_acked),
      .rsp_completed_now (rsp_completed_now),
      .rsp_timed_out_now (rsp_timed_out_now),
      .rsp_is_committed  (rsp_is_committed),
      .rsp_is_complete   (rsp_is_complete),
      .rsp_pending_count (rsp_pending_count),
      .rsp_member_count  (rsp_member_count)
   );

   // an accepted request always passes through the match step, where no request is taken
   a_match_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during match step");

   // a fresh response follows an accepted request through the match and execute steps
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("response without matching request");

   a_timeout_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out_now |-> rsp_completed_now && rsp_is_complete)
      else $error("timeout without completion");

   a_pending_le_members: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_PARTICIPANTS < 32) |-> rsp_pending_count <= rsp_member_count)
      else $error("pending count exceeds member count");

endmodule

FILE: test/ack_barrier_with_timeout_tb.sv
// Testbench for ack_barrier_with_timeout: random and directed barrier requests,
// checked against an in-bench model of the participant table and countdown.
// Depends on abto_pkg and the ack_barrier_with_timeout RTL.
module ack_barrier_with_timeout_tb;
   import abto_pkg::*;

   localparam int MAX_SLOTS = DEFAULT_MAX_PARTICIPANTS;
   localparam int N_PHASES  = 6;
   localparam int PHASE_REQS = 200;
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [REQ_KEY_W-1:0] key;
      logic [SERIAL_W-1:0]  serial;
   } barrier_req_type;

   typedef struct packed {
      logic                   accepted;
      logic                   key_present;
      logic                   key_acked;
      logic                   completed_now;
      logic                   timed_out_now;
      logic                   is_committed;
      logic                   is_complete;
      logic [COUNT_OUT_W-1:0] pending_count;
      logic [COUNT_OUT_W-1:0] member_count;
   } barrier_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = '0;
   logic [REQ_KEY_W-1:0]   req_key = '0;
   logic [SERIAL_W-1:0]    req_serial = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_accepted;
   logic                   rsp_key_present;
   logic                   rsp_key_acked;
   logic                   rsp_completed_now;
   logic                   rsp_timed_out_now;
   logic                   rsp_is_committed;
   logic                   rsp_is_complete;
   logic [COUNT_OUT_W-1:0] rsp_pending_count;
   logic [COUNT_OUT_W-1:0] rsp_member_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [TIMEOUT_W-1:0]   csr_wdata = '0;

   ack_barrier_with_timeout i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_serial        (req_serial),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_key_present   (rsp_key_present),
      .rsp_key_acked     (rsp_key_acked),
      .rsp_completed_now (rsp_completed_now),
      .rsp_timed_out_now (rsp_timed_out_now),
      .rsp_is_committed  (rsp_is_committed),
      .rsp_is_complete   (rsp_is_complete),
      .rsp_pending_count (rsp_pending_count),
      .rsp_member_count  (rsp_member_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Barrier model state
   logic                 tbl_valid [MAX_SLOTS] = '{default: 1'b0};
   logic [REQ_KEY_W-1:0] tbl_key [MAX_SLOTS];
   logic [SERIAL_W-1:0]  tbl_serial [MAX_SLOTS];
   logic                 tbl_acked [MAX_SLOTS];
   int                   n_members = 0;
   int                   n_pending = 0;
   logic                 committed = 1'b0;
   logic                 barrier_done = 1'b0;
   logic                 armed = 1'b0;
   logic [TIMEOUT_W-1:0] countdown = '0;
   logic [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RESET;

   barrier_req_type   req_q [$];
   barrier_rsp_type   rsp_expect_q [$];
   logic [REQ_KEY_W-1:0] key_pool [24];
   logic [REQ_KEY_W-1:0] txn_keys [$];
   logic [SERIAL_W-1:0]  txn_serials [$];

   int   n_queued = 0;
   int   n_accepted = 0;
   int   n_checked = 0;
   int   n_errors = 0;
   int   n_completions = 0;
   int   n_timeouts = 0;
   int   n_csr_writes = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic req_taken = 1'b0;

   function automatic int find_member(logic [REQ_KEY_W-1:0] k);
      int slot;
      slot = -1;
      for (int i = 0; i < MAX_SLOTS; i++)
         if (slot < 0 && tbl_valid[i] && tbl_key[i] == k) slot = i;
      return slot;
   endfunction

   // Fire completion at most once per transaction.
   function automatic logic signal_done();
      if (barrier_done) return 1'b0;
      barrier_done = 1'b1;
      armed = 1'b0;
      countdown = '0;
      return 1'b1;
   endfunction

   function automatic barrier_rsp_type apply_request(logic [OP_W-1:0] op,
                                                     logic [REQ_KEY_W-1:0] k,
                                                     logic [SERIAL_W-1:0] ser);
      barrier_rsp_type r;
      int slot;
      r = '0;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < MAX_SLOTS; i++) tbl_valid[i] = 1'b0;
            n_members = 0;
            n_pending = 0;
            committed = 1'b0;
            barrier_done = 1'b0;
            armed = 1'b0;
            countdown = '0;
            r.accepted = 1'b1;
         end
         OP_ADD: begin
            if (!committed && find_member(k) < 0) begin
               // take the lowest free slot
               for (int i = 0; i < MAX_SLOTS && !r.accepted; i++)
                  if (!tbl_valid[i]) begin
                     tbl_valid[i] = 1'b1;
                     tbl_key[i] = k;
                     tbl_serial[i] = ser;
                     tbl_acked[i] = 1'b0;
                     n_members++;
                     n_pending++;
                     r.accepted = 1'b1;
                  end
            end
         end
         OP_REMOVE: begin
            slot = find_member(k);
            if (slot >= 0) begin
               tbl_valid[slot] = 1'b0;
               if (n_members > 0) n_members--;
               if (!tbl_acked[slot] && n_pending > 0) n_pending--;
               r.accepted = 1'b1;
               if (committed && n_pending == 0) r.completed_now = signal_done();
            end
         end
         OP_ACK: begin
            slot = find_member(k);
            if (slot >= 0 && tbl_serial[slot] == ser && !tbl_acked[slot]) begin
               tbl_acked[slot] = 1'b1;
               if (n_pending > 0) n_pending--;
               r.accepted = 1'b1;
               if (committed && n_pending == 0) r.completed_now = signal_done();
            end
         end
         OP_COMMIT: begin
            if (!committed) begin
               committed = 1'b1;
               r.accepted = 1'b1;
               if (n_pending == 0)
                  r.completed_now = signal_done();
               else if (timeout_cfg != '0 && !barrier_done) begin
                  armed = 1'b1;
                  countdown = timeout_cfg;
               end
            end
         end
         OP_TICK: begin
            if (armed) begin
               r.accepted = 1'b1;
               if (countdown != '0) countdown = countdown - TIMEOUT_W'(1);
               if (countdown == '0) begin
                  armed = 1'b0;
                  r.completed_now = signal_done();
                  r.timed_out_now = r.completed_now;
               end
            end
         end
         default: ;
      endcase
      slot = find_member(k);
      r.key_present   = (slot >= 0);
      r.key_acked     = (slot >= 0) ? tbl_acked[slot] : 1'b0;
      r.is_committed  = committed;
      r.is_complete   = barrier_done;
      r.pending_count = COUNT_OUT_W'(n_pending);
      r.member_count  = COUNT_OUT_W'(n_members);
      return r;
   endfunction

   function automatic string fmt_rsp(barrier_rsp_type r);
      return $sformatf("acc %b pres %b acked %b done %b tmo %b cmt %b cpl %b pend %0d mem %0d",
                       r.accepted, r.key_present, r.key_acked, r.completed_now,
                       r.timed_out_now, r.is_committed, r.is_complete,
                       r.pending_count, r.member_count);
   endfunction

   // Monitor: track config writes, check responses, predict accepted requests.
   always @(posedge clock) begin
      barrier_rsp_type got;
      barrier_rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            timeout_cfg = csr_wdata;
            n_csr_writes++;
         end
         if (rsp_valid && rsp_ready) begin
            got.accepted      = rsp_accepted;
            got.key_present   = rsp_key_present;
            got.key_acked     = rsp_key_acked;
            got.completed_now = rsp_completed_now;
            got.timed_out_now = rsp_timed_out_now;
            got.is_committed  = rsp_is_committed;
            got.is_complete   = rsp_is_complete;
            got.pending_count = rsp_pending_count;
            got.member_count  = rsp_member_count;
            if (rsp_expect_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("response with no request outstanding: %s", fmt_rsp(got));
            end else begin
               want = rsp_expect_q.pop_front();
               n_checked++;
               if (want.completed_now) n_completions++;
               if (want.timed_out_now) n_timeouts++;
               if (got !== want) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("response %0d mismatch\n  expected %s\n  actual   %s",
                              n_checked, fmt_rsp(want), fmt_rsp(got));
               end
            end
         end
         if (req_valid && req_ready) begin
            rsp_expect_q.push_back(apply_request(req_operation, req_key, req_serial));
            n_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // Driver: hold a request until taken, then advance or idle.
   always @(negedge clock) begin
      barrier_req_type nxt;
      if (req_taken || !req_valid) begin
         req_taken = 1'b0;
         if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = req_q.pop_front();
            req_valid     <= 1'b1;
            req_operation <= nxt.op;
            req_key       <= nxt.key;
            req_serial    <= nxt.serial;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic push_req(logic [OP_W-1:0] op, logic [REQ_KEY_W-1:0] k,
                           logic [SERIAL_W-1:0] ser);
      barrier_req_type it;
      it.op = op;
      it.key = k;
      it.serial = ser;
      req_q.push_back(it);
      n_queued++;
   endtask

   function automatic logic [REQ_KEY_W-1:0] rand_key();
      if ($urandom_range(99) < 60) return key_pool[$urandom_range(23)];
      return REQ_KEY_W'($urandom);
   endfunction

   // One action on the current transaction, mostly aimed at known members.
   task automatic push_action();
      int pick;
      int i;
      pick = $urandom_range(99);
      i = (txn_keys.size() != 0) ? $urandom_range(txn_keys.size() - 1) : 0;
      if (pick < 50 && txn_keys.size() != 0)
         push_req(OP_ACK, txn_keys[i], txn_serials[i]);
      else if (pick < 60 && txn_keys.size() != 0)
         push_req(OP_ACK, txn_keys[i], txn_serials[i] ^ (32'h1 << $urandom_range(31)));
      else if (pick < 70)
         push_req(OP_REMOVE, (txn_keys.size() != 0) ? txn_keys[i] : rand_key(), $urandom);
      else if (pick < 85)
         push_req(OP_TICK, rand_key(), $urandom);
      else if (pick < 90)
         push_req(OP_COMMIT, rand_key(), $urandom);
      else if (pick < 95)
         push_req(OP_ADD, rand_key(), $urandom);
      else
         push_req(OP_W'($urandom_range(7)), rand_key(), $urandom);
   endtask

   task automatic gen_transaction();
      int n_add;
      logic big;
      logic [REQ_KEY_W-1:0] k;
      logic [SERIAL_W-1:0] s;
      txn_keys.delete();
      txn_serials.delete();
      if ($urandom_range(9) != 0) push_req(OP_CLEAR, rand_key(), $urandom);
      // big transactions use fresh keys so the table fills up
      big = ($urandom_range(3) == 0);
      n_add = big ? $urandom_range(14, 20) : $urandom_range(0, 8);
      repeat (n_add) begin
         k = big ? REQ_KEY_W'($urandom) : rand_key();
         s = $urandom;
         txn_keys.push_back(k);
         txn_serials.push_back(s);
         push_req(OP_ADD, k, s);
      end
      repeat ($urandom_range(0, 4)) push_action();
      if ($urandom_range(9) != 0) push_req(OP_COMMIT, rand_key(), $urandom);
      repeat (n_add + $urandom_range(0, 10)) push_action();
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (!(n_accepted == n_queued && n_checked == n_accepted));
   endtask

   task automatic write_timeout(logic [TIMEOUT_W-1:0] v);
      @(negedge clock);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] phase_timeout [N_PHASES];
      int target;
      phase_timeout = '{32'd3, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd5};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 24; i++) key_pool[i] = REQ_KEY_W'($urandom);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: refusals, ack rules, spare codes, commit and completion paths
      push_req(OP_CLEAR, 16'h0000, 32'h0);
      push_req(OP_ADD, 16'h0000, 32'h0000_0000);
      push_req(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(OP_ADD, 16'h0000, 32'h1234_5678);
      push_req(OP_ACK, 16'h0000, 32'h0000_0001);
      push_req(OP_ACK, 16'h0000, 32'h0000_0000);
      push_req(OP_ACK, 16'h0000, 32'h0000_0000);
      push_req(OP_ACK, 16'h1234, 32'h0000_0000);
      push_req(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(OP_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(OP_SPARE_B, 16'h0000, 32'h0);
      push_req(OP_COMMIT, 16'h0000, 32'h0);
      push_req(OP_COMMIT, 16'h0000, 32'h0);
      push_req(OP_ADD, 16'h0005, 32'h5);
      push_req(OP_TICK, 16'hFFFF, 32'h0);
      push_req(OP_REMOVE, 16'hFFFF, 32'h0);
      push_req(OP_REMOVE, 16'h0000, 32'h0);
      push_req(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(OP_COMMIT, 16'hFFFF, 32'h0);
      wait_idle();
      write_timeout(32'd1);
      push_req(OP_CLEAR, 16'h0007, 32'h0);
      push_req(OP_ADD, 16'h0007, 32'hA5A5_A5A5);
      push_req(OP_COMMIT, 16'h0007, 32'h0);
      push_req(OP_TICK, 16'h0007, 32'h0);
      push_req(OP_TICK, 16'h0007, 32'h0);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_idle();
         write_timeout(phase_timeout[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         target = n_queued + PHASE_REQS;
         while (n_queued < target) gen_transaction();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("checked %0d responses across %0d timeout writes", n_checked, n_csr_writes);
      $display("barrier completions seen: %0d, of them by timeout: %0d",
               n_completions, n_timeouts);
      if (n_errors == 0 && rsp_expect_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout: %0d of %0d requests accepted", n_accepted, n_queued);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
